// File: hw/rtl/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types, codes and helpers of the styled midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package scr_pkg;

  // field widths
  localparam int CoordBits  = 12;
  localparam int OffBits    = 13;
  localparam int StepBits   = 14;
  localparam int ErrBits    = 17;
  localparam int PixBits    = 14;
  localparam int ColorBits  = 8;
  localparam int StyleBits  = 3;
  localparam int PhaseBits  = 4;
  localparam int CfgIdxBits = 1;

  // pattern period is nine steps, phases 0..8
  localparam logic [PhaseBits-1:0] PhaseLast = 4'd8;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CFG_LINE_STYLE  = 1'b0;
  localparam logic [CfgIdxBits-1:0] CFG_PIXEL_COLOR = 1'b1;

  // line style codes
  localparam logic [StyleBits-1:0] STYLE_SOLID    = 3'd1;
  localparam logic [StyleBits-1:0] STYLE_DASH     = 3'd2;
  localparam logic [StyleBits-1:0] STYLE_DOTTED   = 3'd3;
  localparam logic [StyleBits-1:0] STYLE_DASH_DOT = 3'd4;

  // reset values of the configuration registers
  localparam logic [StyleBits-1:0] StyleReset = STYLE_SOLID;
  localparam logic [ColorBits-1:0] ColorReset = 8'd15;

  // one step request handed from the front to the back
  typedef struct packed {
    logic [CoordBits-1:0]      cx;
    logic [CoordBits-1:0]      cy;
    logic signed [OffBits-1:0] x;
    logic signed [OffBits-1:0] y;
    logic [ColorBits-1:0]      color;
    logic                      draw;
    logic                      done;
  } job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // does the style draw at this pattern phase
  function automatic logic style_draws(input logic [StyleBits-1:0] style,
                                       input logic [PhaseBits-1:0] ph);
    logic r;
    case (style)
      STYLE_SOLID:    r = 1'b1;
      STYLE_DASH:     r = (ph < 4'd6);
      STYLE_DOTTED:   r = (ph == 4'd0);
      STYLE_DASH_DOT: r = ((ph >= 4'd2) && (ph <= 4'd6)) || (ph == PhaseLast);
      default:        r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/scr_front.sv
// ----------------------------------------------------------------------------
// scr_front
// Accepts start and advance requests, queues a job for each, holds the circle
// state and configuration and runs a midpoint step per advance while active.
// ----------------------------------------------------------------------------
module scr_front import scr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic                  start_req,
  input  logic [CoordBits-1:0]  center_x,
  input  logic [CoordBits-1:0]  center_y,
  input  logic [CoordBits-1:0]  radius,
  input  logic                  cfg_we,
  input  logic [CfgIdxBits-1:0] cfg_index,
  input  logic [ColorBits-1:0]  cfg_wdata,
  input  q_stat_t               q_stat,
  output logic                  push,
  output job_t                  push_job
);

  logic [StyleBits-1:0]       line_style;
  logic [ColorBits-1:0]       pixel_color;
  logic [CoordBits-1:0]       centre_x_reg, centre_y_reg, radius_reg;
  logic signed [OffBits-1:0]  offset_x, offset_y, offset_x_next, offset_y_next;
  logic [StepBits-1:0]        step_dx, step_dy, step_dx_next, step_dy_next;
  logic signed [ErrBits-1:0]  decision_error, decision_error_next;
  logic [PhaseBits-1:0]       pattern_phase, pattern_phase_next;
  logic                       active, active_next;

  logic [StepBits-1:0]        dx_plus2;
  logic signed [ErrBits-1:0]  two_r, err_x, err_mid;
  logic                       step_done, accept;

  assign req_ready = !q_stat.full;
  assign accept    = req_valid && req_ready;
  assign push      = accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_style  <= StyleReset;
      pixel_color <= ColorReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_STYLE:  line_style  <= cfg_wdata[StyleBits-1:0];
        CFG_PIXEL_COLOR: pixel_color <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // midpoint step: x check first, y check sees the updated error
  always_comb begin
    two_r    = signed'({{(ErrBits-CoordBits-1){1'b0}}, radius_reg, 1'b0});
    dx_plus2 = step_dx + StepBits'(2);
    err_x    = decision_error + signed'({{(ErrBits-StepBits){1'b0}}, dx_plus2}) - two_r;

    offset_x_next = offset_x;
    step_dx_next  = step_dx;
    err_mid       = decision_error;
    if (decision_error > 0) begin
      offset_x_next = offset_x - OffBits'(1);
      step_dx_next  = dx_plus2;
      err_mid       = err_x;
    end

    offset_y_next       = offset_y;
    step_dy_next        = step_dy;
    decision_error_next = err_mid;
    if (err_mid <= 0) begin
      offset_y_next       = offset_y + OffBits'(1);
      decision_error_next = err_mid + signed'({{(ErrBits-StepBits){1'b0}}, step_dy});
      step_dy_next        = step_dy + StepBits'(2);
    end

    pattern_phase_next = (pattern_phase >= PhaseLast) ? '0 : pattern_phase + PhaseBits'(1);
    step_done          = (offset_x_next < offset_y_next);
    active_next        = !step_done;
  end

  // job built from the state before the step
  always_comb begin
    push_job.cx    = centre_x_reg;
    push_job.cy    = centre_y_reg;
    push_job.x     = offset_x;
    push_job.y     = offset_y;
    push_job.color = pixel_color;
    push_job.draw  = 1'b0;
    push_job.done  = 1'b1;
    if (start_req) begin
      push_job.done = (radius == '0);
    end else if (active) begin
      push_job.draw = style_draws(line_style, pattern_phase);
      push_job.done = step_done;
    end
  end

  // circle state
  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x_reg   <= '0;
      centre_y_reg   <= '0;
      radius_reg     <= '0;
      offset_x       <= '0;
      offset_y       <= '0;
      step_dx        <= StepBits'(1);
      step_dy        <= StepBits'(1);
      decision_error <= '0;
      pattern_phase  <= '0;
      active         <= 1'b0;
    end else if (accept) begin
      if (start_req) begin
        centre_x_reg   <= center_x;
        centre_y_reg   <= center_y;
        radius_reg     <= radius;
        offset_x       <= signed'({1'b0, radius}) - OffBits'(1);
        offset_y       <= '0;
        step_dx        <= StepBits'(1);
        step_dy        <= StepBits'(1);
        decision_error <= ErrBits'(1) - signed'({{(ErrBits-CoordBits-1){1'b0}}, radius, 1'b0});
        pattern_phase  <= '0;
        active         <= (radius != '0);
      end else if (active) begin
        offset_x       <= offset_x_next;
        offset_y       <= offset_y_next;
        step_dx        <= step_dx_next;
        step_dy        <= step_dy_next;
        decision_error <= decision_error_next;
        pattern_phase  <= pattern_phase_next;
        active         <= active_next;
      end
    end
  end

endmodule

// File: hw/rtl/scr_queue.sv
// ----------------------------------------------------------------------------
// scr_queue
// Two-entry job queue between the step front and the pixel back.
// ----------------------------------------------------------------------------
module scr_queue import scr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t q_stat
);

  job_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push || pop)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("job queue underflow");
`endif

endmodule

// File: hw/rtl/scr_back.sv
// ----------------------------------------------------------------------------
// scr_back
// Turns each queued job into one status result or eight octant pixels,
// one result per cycle while res_ready allows, through an output register.
// ----------------------------------------------------------------------------
module scr_back import scr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  job_t                      head,
  input  q_stat_t                   q_stat,
  output logic                      pop,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic signed [PixBits-1:0] pixel_x,
  output logic signed [PixBits-1:0] pixel_y,
  output logic [ColorBits-1:0]      color,
  output logic                      pixel_valid,
  output logic                      last_of_step,
  output logic                      circle_done
);

  logic [2:0]         octant;
  logic               load, last_item, swap, neg_x, neg_y;
  logic [PixBits-1:0] cx_w, cy_w, x_w, y_w, ax, ay, px, py;

  assign load      = !res_valid || res_ready;
  assign last_item = !head.draw || (octant == 3'd7);
  assign pop       = load && !q_stat.empty && last_item;

  // octant symmetry: swap x/y on octants 1,2,5,6, mirror x on 2..5, mirror y on 4..7
  always_comb begin
    swap  = octant[0] ^ octant[1];
    neg_x = octant[1] ^ octant[2];
    neg_y = octant[2];
    cx_w  = {{(PixBits-CoordBits){1'b0}}, head.cx};
    cy_w  = {{(PixBits-CoordBits){1'b0}}, head.cy};
    x_w   = {{(PixBits-OffBits){head.x[OffBits-1]}}, head.x};
    y_w   = {{(PixBits-OffBits){head.y[OffBits-1]}}, head.y};
    ax    = swap ? y_w : x_w;
    ay    = swap ? x_w : y_w;
    px    = neg_x ? cx_w - ax : cx_w + ax;
    py    = neg_y ? cy_w - ay : cy_w + ay;
  end

  // output register and octant counter
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      octant    <= '0;
    end else if (load) begin
      res_valid <= !q_stat.empty;
      if (!q_stat.empty) begin
        octant <= last_item ? 3'd0 : octant + 3'd1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load && !q_stat.empty) begin
      pixel_x      <= head.draw ? signed'(px) : '0;
      pixel_y      <= head.draw ? signed'(py) : '0;
      color        <= head.draw ? head.color : '0;
      pixel_valid  <= head.draw;
      last_of_step <= last_item;
      circle_done  <= head.done;
    end
  end

`ifndef ASSERT_OFF
  a_mid_job_present: assert property (@(posedge clk) disable iff (rst)
    (octant != 3'd0) |-> !q_stat.empty)
    else $error("octant count running without a job");
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !pixel_valid) |-> last_of_step)
    else $error("status result not marked last");
  a_pixel_count: assert property (@(posedge clk) disable iff (rst)
    (res_valid && pixel_valid && !last_of_step) |-> (octant != 3'd0))
    else $error("octant count lost mid step");
`endif

endmodule

// File: hw/rtl/styled_midpoint_circle_raster_top.sv
// an accepted request is written into the job queue, then into the back's output register
// throughput: the front takes one request per cycle while the queue is not full; the back
//   sends one result a cycle while res_ready allows: eight for a drawn step, else one
// a two-entry job queue lets the front run ahead of the pixel back
// reset (synchronous, active high) clears circle state, queue and output, style 1, color 15
// ----------------------------------------------------------------------------
// styled_midpoint_circle_raster_top
// Styled midpoint circle rasterizer with eight-way symmetry.
// ----------------------------------------------------------------------------
module styled_midpoint_circle_raster_top import scr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic                      start_req,
  input  logic [CoordBits-1:0]      center_x,
  input  logic [CoordBits-1:0]      center_y,
  input  logic [CoordBits-1:0]      radius,
  input  logic                      cfg_we,
  input  logic [CfgIdxBits-1:0]     cfg_index,
  input  logic [ColorBits-1:0]      cfg_wdata,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic signed [PixBits-1:0] pixel_x,
  output logic signed [PixBits-1:0] pixel_y,
  output logic [ColorBits-1:0]      color,
  output logic                      pixel_valid,
  output logic                      last_of_step,
  output logic                      circle_done
);

  q_stat_t q_stat;
  job_t    push_job, head;
  logic    push, pop;

  // step front
  scr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .start_req (start_req),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  // job queue
  scr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // pixel back
  scr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .color        (color),
    .pixel_valid  (pixel_valid),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

endmodule
